@@ rtl/pst_pkg.sv @@
// Package for the spanning tree builder: field widths, register and function codes,
// controller states and the command struct of the adjacency RAM.
// No dependencies; used by every file of the block.
package pst_pkg;

  // Default sizes
  localparam int unsigned MaxNodesDef   = 16;
  localparam int unsigned WeightBitsDef = 16;

  // Fixed field widths of the stream and configuration ports
  localparam int unsigned NodeFieldW   = 4;
  localparam int unsigned WeightFieldW = 16;
  localparam int unsigned TotalW       = 20;
  localparam int unsigned InDataW      = 24;
  localparam int unsigned InUserW      = 1;
  localparam int unsigned OutPadW      = 4;
  localparam int unsigned OutDataW     = 48;
  localparam int unsigned OutUserW     = 1;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 5;

  localparam logic [TotalW-1:0] TotalMax = '1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegNodeCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaximize  = 1'b1;

  // Input function codes
  localparam logic FuncEdge = 1'b0;
  localparam logic FuncRun  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RELAX,
    S_EMIT_RD,
    S_EMIT_WR
  } pst_state_e;

  // Access enables toward the adjacency RAM
  typedef struct packed {
    logic wr;
    logic rd;
  } pst_adj_cmd_t;

  // Strict improvement test for minimum or maximum tree
  function automatic logic pst_better(input logic [31:0] cand, input logic [31:0] cur,
                                      input logic maxi);
    return maxi ? (cand > cur) : (cand < cur);
  endfunction

endpackage

@@ rtl/pst_adj_ram.sv @@
// Adjacency RAM of the spanning tree builder: one word per unordered node pair,
// addressed as (lower index, higher index), cleared by a sweep after reset.
// Depends on pst_pkg.
module pst_adj_ram #(
  parameter int unsigned MAX_NODES   = pst_pkg::MaxNodesDef,
  parameter int unsigned WEIGHT_BITS = pst_pkg::WeightBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pst_pkg::pst_adj_cmd_t              cmd_i,
  input  logic [$clog2(MAX_NODES)-1:0]       wr_a_i,
  input  logic [$clog2(MAX_NODES)-1:0]       wr_b_i,
  input  logic [WEIGHT_BITS-1:0]             wr_data_i,
  input  logic [$clog2(MAX_NODES)-1:0]       rd_a_i,
  input  logic [$clog2(MAX_NODES)-1:0]       rd_b_i,
  output logic [WEIGHT_BITS-1:0]             rd_data_o,
  output logic                               busy_o
);
  import pst_pkg::*;

  localparam int unsigned NodeW = $clog2(MAX_NODES);
  localparam int unsigned AddrW = 2 * NodeW;
  localparam int unsigned Depth = 1 << AddrW;

  logic [WEIGHT_BITS-1:0] mem [Depth];
  logic [AddrW-1:0]       waddr;
  logic [AddrW-1:0]       raddr;
  logic [AddrW-1:0]       clr_q;
  logic                   busy_q;
  logic [WEIGHT_BITS-1:0] rd_data_q;

  // Fold both endpoint orders onto one entry
  assign waddr = (wr_a_i <= wr_b_i) ? {wr_a_i, wr_b_i} : {wr_b_i, wr_a_i};
  assign raddr = (rd_a_i <= rd_b_i) ? {rd_a_i, rd_b_i} : {rd_b_i, rd_a_i};

  // Clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.wr) begin
      mem[waddr] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

@@ rtl/prim_spanning_tree.sv @@
// Top level of the spanning tree builder: stream ports, configuration registers,
// Prim controller and the per-node key memory. Depends on pst_pkg and pst_adj_ram.
//
//  channel  | direction | tdata (low bit up)                          | tuser      | tlast
//  s_axis   | in        | node_a, node_b, weight                      | func       | -
//  m_axis   | out       | parent_node, child_node, edge_weight,       | unreached  | last
//           |           | running_total, zero pad                     |            |
//  cfg      | in        | write enable, register index, write data    | -          | -
//
// A run makes one tree step per reached node (n = clamped node_count), each a relax pass
// over nodes 0..n-1 that reads one adjacency word and one key word per cycle; each result
// then reads its key word (S_EMIT_RD) and loads the result register (S_EMIT_WR), held
// while the output stalls. After reset a sweep clears the adjacency RAM with s_axis_tready
// low; configuration writes are taken throughout. The result register lets the next item
// enter while the final result waits.
module prim_spanning_tree #(
  parameter int unsigned MAX_NODES   = pst_pkg::MaxNodesDef,
  parameter int unsigned WEIGHT_BITS = pst_pkg::WeightBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pst_pkg::InDataW-1:0]   s_axis_tdata,   // node_a, node_b, weight
  input  logic [pst_pkg::InUserW-1:0]   s_axis_tuser,   // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pst_pkg::OutDataW-1:0]  m_axis_tdata,   // parent, child, weight, total, pad
  output logic [pst_pkg::OutUserW-1:0]  m_axis_tuser,   // unreached
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [pst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pst_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pst_pkg::*;

  localparam int unsigned NodeW   = $clog2(MAX_NODES);
  localparam int unsigned CntW    = $clog2(MAX_NODES + 1);
  localparam int unsigned KeyMemW = WEIGHT_BITS + NodeW;
  localparam int unsigned SumW    = ((WEIGHT_BITS > TotalW) ? WEIGHT_BITS : TotalW) + 1;

  // Input fields
  logic                    in_func;
  logic [NodeFieldW-1:0]   in_a;
  logic [NodeFieldW-1:0]   in_b;
  logic [WEIGHT_BITS-1:0]  in_w;
  logic                    in_acc;
  logic                    ends_ok;

  assign in_func = s_axis_tuser[0];
  assign in_a    = s_axis_tdata[NodeFieldW-1:0];
  assign in_b    = s_axis_tdata[2*NodeFieldW-1:NodeFieldW];
  assign in_w    = WEIGHT_BITS'(s_axis_tdata[2*NodeFieldW+WeightFieldW-1:2*NodeFieldW]);
  assign ends_ok = (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES);

  // Configuration registers
  logic [CfgDataW-1:0] node_count_q;
  logic                maximize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CfgDataW'(1);
      maximize_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNodeCount: node_count_q <= cfg_data_i;
        RegMaximize:  maximize_q   <= cfg_data_i[0];
      endcase
    end
  end

  // Clamp node count to 1..MAX_NODES
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_eff = CntW'(MAX_NODES);
    end else begin
      n_eff = CntW'(node_count_q);
    end
  end

  // Control state
  pst_state_e             state_q, state_d;
  logic [CntW-1:0]        n_q, n_d, n_m1;
  logic [NodeW-1:0]       u_q, u_d;
  logic [NodeW-1:0]       iss_j_q, iss_j_d;
  logic                   iss_done_q, iss_done_d;
  logic                   p_vld_q, p_vld_d;
  logic [NodeW-1:0]       p_j_q, p_j_d;
  logic                   p_last_q, p_last_d;
  logic                   cand_found_q, cand_found_d;
  logic [NodeW-1:0]       cand_idx_q, cand_idx_d;
  logic [WEIGHT_BITS-1:0] cand_key_q, cand_key_d;
  logic [MAX_NODES-1:0]   in_tree_q, in_tree_d;
  logic [MAX_NODES-1:0]   key_vld_q, key_vld_d;
  logic [TotalW-1:0]      total_q, total_d;
  logic [NodeW-1:0]       emit_idx_q, emit_idx_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_load;

  // Adjacency RAM port
  pst_adj_cmd_t           adj_cmd;
  logic [NodeW-1:0]       adj_wa, adj_wb;
  logic [WEIGHT_BITS-1:0] adj_rdata;
  logic                   adj_busy;

  // Key memory: best key and tree parent per node
  logic [KeyMemW-1:0]     key_mem [MAX_NODES];
  logic                   key_re, key_we;
  logic [NodeW-1:0]       key_raddr, key_waddr;
  logic [KeyMemW-1:0]     key_wdata;
  logic [KeyMemW-1:0]     key_rdata_q;
  logic [WEIGHT_BITS-1:0] kd_key;
  logic [NodeW-1:0]       kd_par;

  assign kd_key = key_rdata_q[KeyMemW-1:NodeW];
  assign kd_par = key_rdata_q[NodeW-1:0];
  assign n_m1   = n_q - CntW'(1);

  // Relax datapath for the node in the process stage
  logic                   cur_in_tree, cur_vld, upd, new_vld, take;
  logic [WEIGHT_BITS-1:0] new_key;
  logic                   cand_found_n;
  logic [NodeW-1:0]       cand_idx_n;
  logic [WEIGHT_BITS-1:0] cand_key_n;

  assign cur_in_tree = in_tree_q[p_j_q];
  assign cur_vld     = key_vld_q[p_j_q];
  assign upd         = (adj_rdata != '0) && !cur_in_tree &&
                       (!cur_vld || pst_better(32'(adj_rdata), 32'(kd_key), maximize_q));
  assign new_vld     = cur_vld || upd;
  assign new_key     = upd ? adj_rdata : kd_key;
  assign take        = p_vld_q && !cur_in_tree && new_vld &&
                       (!cand_found_q || pst_better(32'(new_key), 32'(cand_key_q), maximize_q));
  assign cand_found_n = cand_found_q || take;
  assign cand_idx_n   = take ? p_j_q : cand_idx_q;
  assign cand_key_n   = take ? new_key : cand_key_q;

  // Result datapath
  logic                   e_reached, e_last;
  logic [NodeW-1:0]       e_par;
  logic [WEIGHT_BITS-1:0] e_w;
  logic [SumW-1:0]        e_sum;
  logic [TotalW-1:0]      e_total;

  assign e_reached = in_tree_q[emit_idx_q];
  assign e_par     = e_reached ? kd_par : '0;
  assign e_w       = e_reached ? kd_key : '0;
  assign e_sum     = SumW'(total_q) + SumW'(e_w);
  assign e_total   = (e_sum > SumW'(TotalMax)) ? TotalMax : e_sum[TotalW-1:0];
  assign e_last    = (CntW'(emit_idx_q) == n_m1);

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !adj_busy;

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    u_d          = u_q;
    iss_j_d      = iss_j_q;
    iss_done_d   = iss_done_q;
    p_vld_d      = 1'b0;
    p_j_d        = p_j_q;
    p_last_d     = p_last_q;
    cand_found_d = cand_found_q;
    cand_idx_d   = cand_idx_q;
    cand_key_d   = cand_key_q;
    in_tree_d    = in_tree_q;
    key_vld_d    = key_vld_q;
    total_d      = total_q;
    emit_idx_d   = emit_idx_q;
    out_load     = 1'b0;
    adj_cmd      = '0;
    adj_wa       = NodeW'(in_a);
    adj_wb       = NodeW'(in_b);
    key_re       = 1'b0;
    key_raddr    = iss_j_q;
    key_we       = 1'b0;
    key_waddr    = p_j_q;
    key_wdata    = {adj_rdata, u_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == FuncEdge) begin
            adj_cmd.wr = ends_ok;
          end else begin
            // Start a run from node 0
            n_d          = n_eff;
            in_tree_d    = '0;
            in_tree_d[0] = 1'b1;
            key_vld_d    = '0;
            key_vld_d[0] = 1'b1;
            u_d          = '0;
            iss_j_d      = '0;
            iss_done_d   = 1'b0;
            cand_found_d = 1'b0;
            total_d      = '0;
            state_d      = S_RELAX;
          end
        end
      end

      S_RELAX: begin
        // Issue reads of row u, node j
        if (!iss_done_q) begin
          adj_cmd.rd = 1'b1;
          key_re     = 1'b1;
          p_vld_d    = 1'b1;
          p_j_d      = iss_j_q;
          p_last_d   = (CntW'(iss_j_q) == n_m1);
          if (CntW'(iss_j_q) == n_m1) begin
            iss_done_d = 1'b1;
          end else begin
            iss_j_d = iss_j_q + 1'b1;
          end
        end
        // Relax node j and track the next node to add
        if (p_vld_q) begin
          if (upd) begin
            key_we             = 1'b1;
            key_vld_d[p_j_q]   = 1'b1;
          end
          cand_found_d = cand_found_n;
          cand_idx_d   = cand_idx_n;
          cand_key_d   = cand_key_n;
          if (p_last_q) begin
            if (cand_found_n) begin
              u_d                   = cand_idx_n;
              in_tree_d[cand_idx_n] = 1'b1;
              iss_j_d               = '0;
              iss_done_d            = 1'b0;
              cand_found_d          = 1'b0;
            end else if (n_q == CntW'(1)) begin
              state_d = S_IDLE;
            end else begin
              emit_idx_d = NodeW'(1);
              state_d    = S_EMIT_RD;
            end
          end
        end
      end

      S_EMIT_RD: begin
        key_re    = 1'b1;
        key_raddr = emit_idx_q;
        state_d   = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          total_d  = e_total;
          if (e_last) begin
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_vld_d = (out_vld_q && !m_axis_tready) || out_load;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= CntW'(1);
      u_q          <= '0;
      iss_j_q      <= '0;
      iss_done_q   <= 1'b1;
      p_vld_q      <= 1'b0;
      p_j_q        <= '0;
      p_last_q     <= 1'b0;
      cand_found_q <= 1'b0;
      cand_idx_q   <= '0;
      in_tree_q    <= '0;
      key_vld_q    <= '0;
      total_q      <= '0;
      emit_idx_q   <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      u_q          <= u_d;
      iss_j_q      <= iss_j_d;
      iss_done_q   <= iss_done_d;
      p_vld_q      <= p_vld_d;
      p_j_q        <= p_j_d;
      p_last_q     <= p_last_d;
      cand_found_q <= cand_found_d;
      cand_idx_q   <= cand_idx_d;
      in_tree_q    <= in_tree_d;
      key_vld_q    <= key_vld_d;
      total_q      <= total_d;
      emit_idx_q   <= emit_idx_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_key_q <= cand_key_d;
  end

  // Key memory, registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[key_raddr];
    end
  end

  // Result register
  logic [NodeFieldW-1:0]   out_par_q, out_child_q;
  logic [WeightFieldW-1:0] out_w_q;
  logic [TotalW-1:0]       out_total_q;
  logic                    out_unr_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_par_q   <= NodeFieldW'(e_par);
      out_child_q <= NodeFieldW'(emit_idx_q);
      out_w_q     <= WeightFieldW'(e_w);
      out_total_q <= e_total;
      out_unr_q   <= !e_reached;
      out_last_q  <= e_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_total_q, out_w_q, out_child_q, out_par_q};
  assign m_axis_tuser  = out_unr_q;
  assign m_axis_tlast  = out_last_q;

  pst_adj_ram #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_adj_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (adj_cmd),
    .wr_a_i    (adj_wa),
    .wr_b_i    (adj_wb),
    .wr_data_i (in_w),
    .rd_a_i    (u_q),
    .rd_b_i    (iss_j_q),
    .rd_data_o (adj_rdata),
    .busy_o    (adj_busy)
  );

endmodule

@@ rtl/pst_checker.sv @@
// Port-level checks of the spanning tree builder and the bind that attaches them.
// Depends on pst_pkg and prim_spanning_tree.
module pst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pst_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [pst_pkg::OutUserW-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);
  import pst_pkg::*;

  localparam int unsigned ChildLo = NodeFieldW;
  localparam int unsigned WLo     = 2 * NodeFieldW;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An unreached node carries no parent and no weight
  a_unreached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[NodeFieldW-1:0] == '0) &&
      (m_axis_tdata[WLo+WeightFieldW-1:WLo] == '0))
    else $error("unreached node with parent or weight");

  // Node 0 is the root and is never reported
  a_child_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ChildLo+NodeFieldW-1:ChildLo] != '0)
    else $error("root reported as child");

endmodule

bind prim_spanning_tree pst_checker u_pst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/pst_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the spanning tree builder: mirrors edge and register writes,
// predicts the result stream of every run and compares it with m_axis.
// Depends on pst_pkg only.
module pst_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [pst_pkg::InDataW-1:0]   s_axis_tdata,   // node_a, node_b, weight
  input  logic [pst_pkg::InUserW-1:0]   s_axis_tuser,   // func
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [pst_pkg::OutDataW-1:0]  m_axis_tdata,   // parent, child, weight, total, pad
  input  logic [pst_pkg::OutUserW-1:0]  m_axis_tuser,   // unreached
  input  logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [pst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pst_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import pst_pkg::*;

  localparam int unsigned Nodes = MaxNodesDef;

  typedef struct packed {
    logic [NodeFieldW-1:0]   parent;
    logic [NodeFieldW-1:0]   child;
    logic [WeightFieldW-1:0] weight;
    logic [TotalW-1:0]       total;
    logic                    unreached;
    logic                    last;
  } tree_res_t;

  // Mirror of the block state and registers
  logic [WeightFieldW-1:0] adj_w [Nodes][Nodes];
  logic [4:0]              nodes_cfg;
  logic                    maxi_cfg;
  tree_res_t               tree_res_q[$];
  tree_res_t               got_res;
  tree_res_t               want_res;
  int unsigned             fails = 0;

  // Strict improvement for the selected tree kind
  function automatic bit is_better(input logic [WeightFieldW-1:0] cand,
                                   input logic [WeightFieldW-1:0] cur, input logic maxi);
    return maxi ? (cand > cur) : (cand < cur);
  endfunction

  // Grow the tree from node 0 and queue one result per node 1..n-1
  task automatic predict_tree();
    int unsigned             n;
    int unsigned             u;
    bit                      found;
    logic [WeightFieldW-1:0] key [Nodes];
    bit                      key_ok [Nodes];
    bit                      joined [Nodes];
    logic [NodeFieldW-1:0]   par [Nodes];
    logic [WeightFieldW-1:0] w;
    logic [TotalW:0]         sum;
    tree_res_t               r;
    n = nodes_cfg;
    if (n < 1) n = 1;
    if (n > Nodes) n = Nodes;
    for (int i = 0; i < Nodes; i++) begin
      key[i]    = '0;
      key_ok[i] = 1'b0;
      joined[i] = 1'b0;
      par[i]    = '0;
    end
    key_ok[0] = 1'b1;
    for (int step = 0; step < n; step++) begin
      found = 1'b0;
      u     = 0;
      // pick the best key outside the tree, lowest index on ties
      for (int j = 0; j < n; j++) begin
        if (!joined[j] && key_ok[j] && (!found || is_better(key[j], key[u], maxi_cfg))) begin
          u     = j;
          found = 1'b1;
        end
      end
      if (!found) break;
      joined[u] = 1'b1;
      // relax the neighbors of the new tree node
      for (int j = 0; j < n; j++) begin
        w = adj_w[u][j];
        if (w != '0 && !joined[j] && (!key_ok[j] || is_better(w, key[j], maxi_cfg))) begin
          key[j]    = w;
          key_ok[j] = 1'b1;
          par[j]    = NodeFieldW'(u);
        end
      end
    end
    sum = '0;
    for (int i = 1; i < n; i++) begin
      r       = '0;
      r.child = NodeFieldW'(i);
      if (joined[i]) begin
        r.parent = par[i];
        r.weight = adj_w[par[i]][i];
        sum      = sum + (TotalW+1)'(r.weight);
        if (sum > {1'b0, TotalMax}) sum = {1'b0, TotalMax};
      end else begin
        r.unreached = 1'b1;
      end
      r.total = sum[TotalW-1:0];
      r.last  = (i == n - 1);
      tree_res_q.push_back(r);
    end
  endtask

  task automatic report(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Track every transaction on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < Nodes; a++)
        for (int b = 0; b < Nodes; b++)
          adj_w[a][b] = '0;
      nodes_cfg = 5'd1;
      maxi_cfg  = 1'b0;
      tree_res_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == FuncRun) begin
          predict_tree();
        end else begin
          adj_w[s_axis_tdata[3:0]][s_axis_tdata[7:4]] = s_axis_tdata[23:8];
          adj_w[s_axis_tdata[7:4]][s_axis_tdata[3:0]] = s_axis_tdata[23:8];
        end
      end
      // a register write takes effect after this edge
      if (cfg_we_i) begin
        if (cfg_idx_i == RegNodeCount) nodes_cfg = cfg_data_i;
        else if (cfg_idx_i == RegMaximize) maxi_cfg = cfg_data_i[0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.parent    = m_axis_tdata[3:0];
        got_res.child     = m_axis_tdata[7:4];
        got_res.weight    = m_axis_tdata[23:8];
        got_res.total     = m_axis_tdata[43:24];
        got_res.unreached = m_axis_tuser[0];
        got_res.last      = m_axis_tlast;
        if (tree_res_q.size() == 0) begin
          report($sformatf("result for child %0d with nothing expected", got_res.child));
        end else begin
          want_res = tree_res_q.pop_front();
          check_field("parent_node", got_res.parent, want_res.parent);
          check_field("child_node", got_res.child, want_res.child);
          check_field("edge_weight", got_res.weight, want_res.weight);
          check_field("running_total", got_res.total, want_res.total);
          check_field("unreached", got_res.unreached, want_res.unreached);
          check_field("last", got_res.last, want_res.last);
        end
      end
      fail_count_o <= fails;
      pending_o    <= tree_res_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the spanning tree testbench: clock, reset, edge and run stimulus, register
// phases, output back-pressure and the verdict. Depends on pst_pkg, prim_spanning_tree
// and pst_scoreboard.
module tb_top;
  import pst_pkg::*;

  localparam int unsigned HoldCycles   = 500;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned DrainCycles  = 600;
  localparam int unsigned PhaseItems   = 40;
  localparam int unsigned NumPhases    = 10;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [InUserW-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;
  logic                 m_axis_tlast;
  int unsigned          fail_count;
  int unsigned          pending_cnt;
  int unsigned          res_seen  = 0;
  bit                   no_gaps   = 1'b0;
  logic [4:0]           phase_n  [NumPhases] = '{16, 16, 2, 9, 17, 1, 0, 31, 3, 16};
  logic                 phase_mx [NumPhases] = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0};

  prim_spanning_tree u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pst_scoreboard u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cnt)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Zero, full scale, small values that tie, or anything
  function automatic logic [WeightFieldW-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return WeightFieldW'($urandom_range(1, 8));
    return WeightFieldW'($urandom_range(0, 65535));
  endfunction

  // Mostly nodes in use, now and then any node
  function automatic logic [NodeFieldW-1:0] pick_node(input int unsigned used);
    if ($urandom_range(0, 6) == 0) return NodeFieldW'($urandom_range(0, 15));
    return NodeFieldW'($urandom_range(0, used - 1));
  endfunction

  // Offer one item after a random gap and hold it until the transaction
  task automatic send_item(input logic func, input logic [NodeFieldW-1:0] node_a,
                           input logic [NodeFieldW-1:0] node_b,
                           input logic [WeightFieldW-1:0] weight);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {weight, node_b, node_a};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering, wait for every expected result, then let the block settle
  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] nodes, input logic maxi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegNodeCount;
    cfg_data_i <= nodes;
    @(posedge clk_i);
    cfg_idx_i  <= RegMaximize;
    cfg_data_i <= {4'b0, maxi};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One register setting: graph edits followed by a run, plus some noise
  task automatic run_phase(input logic [4:0] nodes, input logic maxi);
    int unsigned sent;
    int unsigned used;
    int unsigned edits;
    drain_idle();
    set_config(nodes, maxi);
    used = (nodes == 0) ? 1 : (nodes > MaxNodesDef) ? MaxNodesDef : nodes;
    sent = 0;
    while (sent < PhaseItems) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), NodeFieldW'($urandom), NodeFieldW'($urandom),
                  WeightFieldW'($urandom));
        sent++;
      end else begin
        // keep the phase at its item budget
        edits = $urandom_range(1, used + 4);
        if (edits > PhaseItems - sent - 1) edits = PhaseItems - sent - 1;
        repeat (edits) begin
          send_item(FuncEdge, pick_node(used), pick_node(used), pick_weight());
          sent++;
        end
        send_item(FuncRun, NodeFieldW'($urandom), NodeFieldW'($urandom),
                  WeightFieldW'($urandom));
        sent++;
        if ($urandom_range(0, 7) == 0) drain_idle();
      end
    end
    no_gaps = 1'b0;
  endtask

  // Count result transactions for the long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) res_seen <= res_seen + 1;
  end

  // Receiver: random bursts and gaps, one long hold-off once results flow
  initial begin
    int unsigned burst;
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && res_seen >= 60) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 8);
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single node after reset: a run returns nothing
    send_item(FuncRun, 4'hF, 4'hF, 16'hFFFF);
    drain_idle();

    // minimum tree with a tie, a self loop and an unreached node
    set_config(5'd4, 1'b0);
    send_item(FuncEdge, 4'd0, 4'd1, 16'hFFFF);
    send_item(FuncEdge, 4'd1, 4'd2, 16'd1);
    send_item(FuncEdge, 4'd2, 4'd0, 16'd1);
    send_item(FuncEdge, 4'd3, 4'd3, 16'd7);
    send_item(FuncRun, 4'd0, 4'd0, 16'd0);
    drain_idle();

    // maximum tree over the same graph, garbage in the run fields
    set_config(5'd4, 1'b1);
    send_item(FuncRun, 4'hA, 4'h5, 16'h1234);
    drain_idle();

    // all nodes: edge removal, top node index, mostly unreached
    set_config(5'd16, 1'b0);
    send_item(FuncEdge, 4'd1, 4'd0, 16'd0);
    send_item(FuncEdge, 4'd2, 4'd3, 16'h8000);
    send_item(FuncEdge, 4'd15, 4'd0, 16'hFFFF);
    send_item(FuncEdge, 4'd15, 4'd14, 16'd1);
    send_item(FuncRun, 4'hF, 4'h0, 16'hFFFF);
    drain_idle();

    // node counts out of range: zero acts as one, above the maximum is clamped
    set_config(5'd0, 1'b1);
    send_item(FuncRun, 4'd0, 4'd0, 16'd0);
    drain_idle();
    set_config(5'd31, 1'b0);
    send_item(FuncRun, 4'd0, 4'd0, 16'd0);

    // random phases over several settings
    phase_n[7] = 5'($urandom_range(0, 31));
    for (int p = 0; p < NumPhases; p++) run_phase(phase_n[p], phase_mx[p]);

    drain_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pst_pkg.sv
rtl/pst_adj_ram.sv
rtl/prim_spanning_tree.sv
rtl/pst_checker.sv
test/pst_checker.sv
test/tb_top.sv
